FILE: design/xkb64_pkg.sv
`timescale 1ns / 1ps

package xkb64_pkg;

    localparam int KEY_LEN = 73;

    localparam logic [KEY_LEN*8-1:0] KEY_BITS =
        {"~!:?$*<(qw2e5o7i8x12c6m67s98w43d2l45we82q3iuu1z4xle23rt4oxclle34e54u6r8m", 8'h00};

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        STATUS_OK            = 3'd0,
        STATUS_BAD_CHAR      = 3'd1,
        STATUS_TOO_MANY_PADS = 3'd2,
        STATUS_BAD_LENGTH    = 3'd3,
        STATUS_TOO_LONG      = 3'd4
    } status_t;

    typedef struct packed {
        logic             valid;
        logic [5:0]       value;
    } sextet_t;

    // Command from the front to the back: up to three bytes, then an optional status.
    typedef struct packed {
        logic [1:0]       n_bytes;
        logic [2:0][7:0]  bytes;
        logic             has_status;
        status_t          status;
    } cmd_t;

    function automatic logic [7:0] key_byte(input logic [6:0] idx);
        logic [6:0] rev;
        begin
            rev = 7'(KEY_LEN - 1) - idx;
            key_byte = (idx < 7'(KEY_LEN)) ? KEY_BITS[{rev, 3'b000} +: 8] : 8'h00;
        end
    endfunction

    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t s;
        begin
            s.valid = 1'b1;
            s.value = 6'd0;
            if (c >= "A" && c <= "Z")
            begin
                s.value = 6'(c - "A");
            end
            else if (c >= "a" && c <= "z")
            begin
                s.value = 6'(c - "a" + 8'd26);
            end
            else if (c >= "0" && c <= "9")
            begin
                s.value = 6'(c - "0" + 8'd52);
            end
            else if (c == "+")
            begin
                s.value = 6'd62;
            end
            else if (c == "/")
            begin
                s.value = 6'd63;
            end
            else
            begin
                s.valid = 1'b0;
            end
            sextet_of = s;
        end
    endfunction

endpackage

FILE: design/xkb64_in_if.sv
`timescale 1ns / 1ps

interface xkb64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       has_char;
    logic       end_of_string;

    modport source (output valid, output ch, output has_char, output end_of_string,
                    input ready);
    modport sink   (input valid, input ch, input has_char, input end_of_string,
                    output ready);
endinterface

FILE: design/xkb64_out_if.sv
`timescale 1ns / 1ps

interface xkb64_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output kind, output data_byte, output status,
                    output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input status,
                    input last, output ready);
endinterface

FILE: design/xkb64_front.sv
`timescale 1ns / 1ps

module xkb64_front (
    input  logic              clk,
    input  logic              rst_n,
    xkb64_in_if.sink          text,
    input  logic              full,
    output logic              push,
    output xkb64_pkg::cmd_t   cmd
);

    logic [23:0]           acc_reg, acc_next, acc_shift;
    logic [1:0]            gp_reg, gp_next;
    logic [1:0]            pc_reg, pc_next;
    logic [6:0]            oc_reg, oc_next;
    xkb64_pkg::status_t    err_reg, err_next;
    xkb64_pkg::sextet_t    dec;
    logic                  accept;
    logic                  ok;
    logic [5:0]            v;
    logic [6:0]            cap;
    logic [1:0]            nb;
    logic [1:0]            emit;

    assign text.ready = !full;
    assign accept     = text.valid && !full;
    assign dec        = xkb64_pkg::sextet_of(text.ch);
    assign cap        = 7'(xkb64_pkg::KEY_LEN) - oc_reg;

    always_comb
    begin
        acc_next  = acc_reg;
        gp_next   = gp_reg;
        pc_next   = pc_reg;
        oc_next   = oc_reg;
        err_next  = err_reg;
        ok        = 1'b1;
        v         = 6'd0;
        acc_shift = 24'd0;
        nb        = 2'd0;
        emit      = 2'd0;
        cmd.has_status = 1'b0;
        cmd.status     = xkb64_pkg::STATUS_OK;

        if (accept && text.has_char && err_reg == xkb64_pkg::STATUS_OK)
        begin
            if (text.ch == xkb64_pkg::PAD_CHAR)
            begin
                if (pc_reg == 2'd2)
                begin
                    err_next = xkb64_pkg::STATUS_TOO_MANY_PADS;
                    ok       = 1'b0;
                end
                else
                begin
                    pc_next = pc_reg + 2'd1;
                end
            end
            else if (!dec.valid)
            begin
                err_next = xkb64_pkg::STATUS_BAD_CHAR;
                ok       = 1'b0;
            end
            else
            begin
                v = dec.value;
            end

            if (ok)
            begin
                acc_shift = {acc_reg[17:0], v};
                if (gp_reg == 2'd3)
                begin
                    // Fewer bytes for more pads; clip at the end of the key.
                    nb = 2'd3 - pc_next;
                    if ({5'd0, nb} <= cap)
                    begin
                        emit = nb;
                    end
                    else
                    begin
                        emit     = cap[1:0];
                        err_next = xkb64_pkg::STATUS_TOO_LONG;
                    end
                    oc_next  = oc_reg + {5'd0, emit};
                    acc_next = 24'd0;
                    pc_next  = 2'd0;
                    gp_next  = 2'd0;
                end
                else
                begin
                    acc_next = acc_shift;
                    gp_next  = gp_reg + 2'd1;
                end
            end
        end

        if (accept && text.end_of_string)
        begin
            cmd.has_status = 1'b1;
            if (err_next != xkb64_pkg::STATUS_OK)
            begin
                cmd.status = err_next;
            end
            else if (gp_next != 2'd0)
            begin
                cmd.status = xkb64_pkg::STATUS_BAD_LENGTH;
            end
            acc_next = 24'd0;
            gp_next  = 2'd0;
            pc_next  = 2'd0;
            oc_next  = 7'd0;
            err_next = xkb64_pkg::STATUS_OK;
        end

        cmd.n_bytes  = emit;
        cmd.bytes[0] = acc_shift[23:16] ^ xkb64_pkg::key_byte(oc_reg);
        cmd.bytes[1] = acc_shift[15:8]  ^ xkb64_pkg::key_byte(oc_reg + 7'd1);
        cmd.bytes[2] = acc_shift[7:0]   ^ xkb64_pkg::key_byte(oc_reg + 7'd2);
    end

    assign push = accept && (emit != 2'd0 || text.end_of_string);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 24'd0;
            gp_reg  <= 2'd0;
            pc_reg  <= 2'd0;
            oc_reg  <= 7'd0;
            err_reg <= xkb64_pkg::STATUS_OK;
        end
        else
        begin
            acc_reg <= acc_next;
            gp_reg  <= gp_next;
            pc_reg  <= pc_next;
            oc_reg  <= oc_next;
            err_reg <= err_next;
        end
    end

endmodule

FILE: design/xkb64_queue.sv
`timescale 1ns / 1ps

module xkb64_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  xkb64_pkg::cmd_t   push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output xkb64_pkg::cmd_t   head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xkb64_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        begin
            wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

FILE: design/xkb64_back.sv
`timescale 1ns / 1ps

module xkb64_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  xkb64_pkg::cmd_t   head,
    output logic              pop,
    xkb64_out_if.source       result
);

    logic [1:0]  idx_reg;
    logic        out_valid_reg;
    logic        kind_reg;
    logic [7:0]  data_reg;
    logic [2:0]  status_reg;
    logic        last_reg;
    logic [2:0]  n_res;
    logic        is_last;
    logic        is_byte;
    logic        load;
    logic [7:0]  sel_byte;

    assign n_res   = {1'b0, head.n_bytes} + {2'b00, head.has_status};
    assign is_last = {1'b0, idx_reg} == (n_res - 3'd1);
    assign is_byte = idx_reg < head.n_bytes;
    assign load    = head_valid && (!out_valid_reg || result.ready);
    assign pop     = load && is_last;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    sel_byte = head.bytes[0];
            2'd1:    sel_byte = head.bytes[1];
            2'd2:    sel_byte = head.bytes[2];
            default: sel_byte = 8'h00;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= is_byte ? xkb64_pkg::KIND_BYTE : xkb64_pkg::KIND_STATUS;
            data_reg   <= is_byte ? sel_byte : 8'h00;
            status_reg <= is_byte ? 3'(xkb64_pkg::STATUS_OK) : 3'(head.status);
            last_reg   <= is_last;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.kind      = kind_reg;
    assign result.data_byte = data_reg;
    assign result.status    = status_reg;
    assign result.last      = last_reg;

endmodule

FILE: design/xor_keyed_base64_decoder.sv
`timescale 1ns / 1ps

// Keyed base64 decoder. Takes one text character per cycle on "text" and
// returns decoded bytes, each XORed with a fixed 73-byte key at its output
// position, followed by one status result when end_of_string is seen; a
// nonzero status means every byte already delivered for that string is to be
// discarded. A character is accepted in any cycle the command queue between
// the decode front and the output serializer has room, so input runs at one
// character per cycle while the consumer keeps up. Results leave the output
// register at one per cycle while result.ready holds; a character yields 0
// to 4 results, so the serializer sets the sustained rate: one per cycle for
// plain text (at most 3 bytes per 4 characters), and a closing character
// that releases 3 bytes plus a status holds the serializer until all four
// results have left, with QUEUE_DEPTH commands absorbing such bursts. Each
// result passes through the command queue and then the output register.
module xor_keyed_base64_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    xkb64_in_if.sink      text,
    xkb64_out_if.source   result
);

    xkb64_pkg::cmd_t  push_cmd;
    xkb64_pkg::cmd_t  head_cmd;
    logic             push;
    logic             full;
    logic             head_valid;
    logic             pop;

    xkb64_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text),
        .full  (full),
        .push  (push),
        .cmd   (push_cmd)
    );

    xkb64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head_cmd)
    );

    xkb64_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head_cmd),
        .pop        (pop),
        .result     (result)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("command queue overflow");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty command queue");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind == xkb64_pkg::KIND_STATUS) |-> result.last)
        else $error("status result not marked last");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.kind == xkb64_pkg::KIND_STATUS) |->
        (result.status <= 3'(xkb64_pkg::STATUS_TOO_LONG)))
        else $error("status code out of range");

endmodule
